/* src/kre_pkg.sv */
// Shared types, constants and helpers for the keyed record extractor.
package kre_pkg;

    localparam int WINDOW_BYTES       = 16;
    localparam int INT_FIELD_BYTES    = 4;
    localparam int TEXT_LEN_BYTES     = 2;
    localparam int DEF_MAX_FIELDS     = 16;
    localparam int DEF_KEY_BYTES      = 16;

    localparam logic [1:0] CFG_KEY_UPPER   = 2'd0;
    localparam logic [1:0] CFG_KEY_LOWER   = 2'd1;
    localparam logic [1:0] CFG_FIELD_COUNT = 2'd2;

    localparam logic [1:0] KIND_INT    = 2'd0;
    localparam logic [1:0] KIND_LENGTH = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_TRUNC_LEN  = 2'd2;
    localparam logic [1:0] ST_TRUNC_TEXT = 2'd3;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_FIELDS,
        PH_LENGTH,
        PH_TEXT,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [31:0] offset;
        logic [1:0]  status;
        logic        fin;
    } res_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctl_t;

    function automatic logic [7:0] key_byte(input logic [127:0] key, input int idx);
        return key[127 - 8 * idx -: 8];
    endfunction

endpackage

/* src/keyed_record_extractor.sv */
// Keyed record extractor top level: config registers, input and result registers.
// An accepted word is held in the input register; its parse step writes any result to the result register.
// Throughput: one byte per cycle; the parse step runs once per cycle between the
// input register and the result register, gated only by the result register's stall.
// Reset: asynchronous active low; clears key, field count, control state and both
// valid flags; the match window contents need no reset (fill count is cleared).
module keyed_record_extractor #(
    parameter int MAX_FIELDS = kre_pkg::DEF_MAX_FIELDS,
    parameter int KEY_BYTES  = kre_pkg::DEF_KEY_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               stream_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic signed [31:0] value,
    output logic [31:0]        record_offset,
    output logic [1:0]         status,
    output logic               final_res
);
    import kre_pkg::*;

    logic [63:0] key_upper_reg;
    logic [63:0] key_lower_reg;
    logic [4:0]  field_count_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_reg;

    logic        out_valid_reg;
    res_t        out_reg;

    logic        advance;
    logic        step;
    logic        hit;
    logic        emit;
    res_t        res;
    win_ctl_t    win_ctl;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg   <= '0;
            key_lower_reg   <= '0;
            field_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_UPPER:   key_upper_reg   <= cfg_data;
                CFG_KEY_LOWER:   key_lower_reg   <= cfg_data;
                CFG_FIELD_COUNT: field_count_reg <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= stream_end;
        end
    end

    kre_match #(
        .KEY_BYTES (KEY_BYTES)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .data_byte (s1_byte_reg),
        .key       ({key_upper_reg, key_lower_reg}),
        .hit       (hit)
    );

    kre_parser #(
        .MAX_FIELDS (MAX_FIELDS),
        .KEY_BYTES  (KEY_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (s1_byte_reg),
        .stream_end  (s1_end_reg),
        .field_count (field_count_reg),
        .hit         (hit),
        .win_ctl     (win_ctl),
        .emit        (emit),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign value         = signed'(out_reg.value);
    assign record_offset = out_reg.offset;
    assign status        = out_reg.status;
    assign final_res     = out_reg.fin;

    a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_end_reg))
        else $error("input word lost while stalled");

endmodule

/* src/kre_match.sv */
// Sliding byte window and key compare.
module kre_match #(
    parameter int KEY_BYTES = kre_pkg::DEF_KEY_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kre_pkg::win_ctl_t ctl,
    input  logic [7:0]        data_byte,
    input  logic [127:0]      key,
    output logic              hit
);
    import kre_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

    logic [7:0]        win_reg     [WINDOW_BYTES];
    logic [7:0]        win_shifted [WINDOW_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              eq;

    always_comb
    begin
        for (int i = 0; i < WINDOW_BYTES - 1; i++)
        begin
            win_shifted[i] = win_reg[i + 1];
        end
        win_shifted[WINDOW_BYTES - 1] = data_byte;
    end

    always_comb
    begin
        if (fill_reg < FILL_W'(WINDOW_BYTES))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_comb
    begin
        eq = 1'b1;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (win_shifted[WINDOW_BYTES - KEY_BYTES + i] != key_byte(key, i))
            begin
                eq = 1'b0;
            end
        end
        hit = eq && (fill_next >= FILL_W'(KEY_BYTES));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            for (int i = 0; i < WINDOW_BYTES; i++)
            begin
                win_reg[i] <= win_shifted[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctl.clear)
        begin
            fill_reg <= '0;
        end
        else if (ctl.shift)
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

/* src/kre_parser.sv */
// Record parser state machine: phase, counters, accumulator and result build.
module kre_parser #(
    parameter int MAX_FIELDS = kre_pkg::DEF_MAX_FIELDS,
    parameter int KEY_BYTES  = kre_pkg::DEF_KEY_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              stream_end,
    input  logic [4:0]        field_count,
    input  logic              hit,
    output kre_pkg::win_ctl_t win_ctl,
    output logic              emit,
    output kre_pkg::res_t     res
);
    import kre_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] bytes_seen_reg, bytes_seen_next;
    logic [4:0]  field_index_reg, field_index_next;
    logic [1:0]  biw_reg, biw_next;
    logic [31:0] accum_reg, accum_next;
    logic [15:0] text_rem_reg, text_rem_next;
    logic [31:0] offset_reg, offset_next;

    logic [4:0]  active;
    logic [4:0]  field_inc;
    logic [31:0] field_word;
    logic [15:0] len_word;
    logic [15:0] text_dec;
    logic [31:0] match_pos;

    always_comb
    begin
        active     = (32'(field_count) > MAX_FIELDS) ? 5'(MAX_FIELDS) : field_count;
        field_inc  = 5'(field_index_reg + 5'd1);
        field_word = {accum_reg[23:0], data_byte};
        len_word   = {accum_reg[7:0], data_byte};
        text_dec   = 16'(text_rem_reg - 16'd1);
        match_pos  = 32'(bytes_seen_reg - 32'(KEY_BYTES - 1));
    end

    assign win_ctl.shift = step && (phase_reg == PH_SEARCH);
    assign win_ctl.clear = step && stream_end;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (hit)
                begin
                    phase_next = (active != 5'd0) ? PH_FIELDS : PH_LENGTH;
                end
            end
            PH_FIELDS:
            begin
                if (biw_reg >= 2'(INT_FIELD_BYTES - 1) && field_inc >= active)
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                if (biw_reg >= 2'(TEXT_LEN_BYTES - 1))
                begin
                    phase_next = (len_word == 16'd0) ? PH_DONE : PH_TEXT;
                end
            end
            PH_TEXT:
            begin
                if (text_dec == 16'd0)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase
        if (stream_end)
        begin
            phase_next = PH_SEARCH;
        end
    end

    // result and datapath
    always_comb
    begin
        emit             = 1'b0;
        res.kind         = KIND_STATUS;
        res.value        = '0;
        res.offset       = offset_reg;
        res.status       = ST_OK;
        res.fin          = 1'b0;
        bytes_seen_next  = bytes_seen_reg;
        field_index_next = field_index_reg;
        biw_next         = biw_reg;
        accum_next       = accum_reg;
        text_rem_next    = text_rem_reg;
        offset_next      = offset_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                bytes_seen_next = 32'(bytes_seen_reg + 32'd1);
                if (hit)
                begin
                    emit             = 1'b1;
                    offset_next      = match_pos;
                    res.offset       = match_pos;
                    field_index_next = '0;
                    biw_next         = '0;
                    accum_next       = '0;
                    if (stream_end)
                    begin
                        res.status = ST_TRUNC_LEN;
                        res.fin    = 1'b1;
                    end
                end
                else if (stream_end)
                begin
                    emit       = 1'b1;
                    res.offset = '0;
                    res.status = ST_NOT_FOUND;
                    res.fin    = 1'b1;
                end
            end
            PH_FIELDS:
            begin
                if (biw_reg >= 2'(INT_FIELD_BYTES - 1))
                begin
                    emit             = 1'b1;
                    res.kind         = KIND_INT;
                    res.value        = field_word;
                    field_index_next = field_inc;
                    biw_next         = '0;
                    accum_next       = '0;
                end
                else
                begin
                    biw_next   = 2'(biw_reg + 2'd1);
                    accum_next = field_word;
                end
                if (stream_end)
                begin
                    emit       = 1'b1;
                    res.status = ST_TRUNC_LEN;
                    res.fin    = 1'b1;
                end
            end
            PH_LENGTH:
            begin
                if (biw_reg >= 2'(TEXT_LEN_BYTES - 1))
                begin
                    emit          = 1'b1;
                    res.kind      = KIND_LENGTH;
                    res.value     = {16'd0, len_word};
                    text_rem_next = len_word;
                    biw_next      = '0;
                    accum_next    = '0;
                    if (len_word == 16'd0)
                    begin
                        res.fin = 1'b1;
                    end
                    else if (stream_end)
                    begin
                        res.status = ST_TRUNC_TEXT;
                        res.fin    = 1'b1;
                    end
                end
                else
                begin
                    biw_next   = 2'd1;
                    accum_next = {16'd0, len_word};
                    if (stream_end)
                    begin
                        emit       = 1'b1;
                        res.status = ST_TRUNC_LEN;
                        res.fin    = 1'b1;
                    end
                end
            end
            PH_TEXT:
            begin
                emit          = 1'b1;
                res.kind      = KIND_TEXT;
                res.value     = {24'd0, data_byte};
                text_rem_next = text_dec;
                if (text_dec == 16'd0)
                begin
                    res.fin = 1'b1;
                end
                else if (stream_end)
                begin
                    res.status = ST_TRUNC_TEXT;
                    res.fin    = 1'b1;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        // rearm for the next stream
        if (stream_end)
        begin
            bytes_seen_next  = '0;
            field_index_next = '0;
            biw_next         = '0;
            accum_next       = '0;
            text_rem_next    = '0;
            offset_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SEARCH;
            bytes_seen_reg  <= '0;
            field_index_reg <= '0;
            biw_reg         <= '0;
            accum_reg       <= '0;
            text_rem_reg    <= '0;
            offset_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bytes_seen_reg  <= bytes_seen_next;
            field_index_reg <= field_index_next;
            biw_reg         <= biw_next;
            accum_reg       <= accum_next;
            text_rem_reg    <= text_rem_next;
            offset_reg      <= offset_next;
        end
    end

    a_text_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TEXT |-> text_rem_reg != 16'd0)
        else $error("text phase with zero remaining count");

    a_length_biw: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LENGTH |-> biw_reg <= 2'd1)
        else $error("length phase byte counter out of range");

    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        step && stream_end |=> phase_reg == PH_SEARCH && bytes_seen_reg == 32'd0)
        else $error("stream end did not rearm the parser");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for keyed_record_extractor: directed and random byte streams, shadow parser, checks.
module tb_top;
    import kre_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_WORDS   = 270;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } in_word_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [1:0]         cfg_index  = CFG_KEY_UPPER;
    logic [63:0]        cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte  = '0;
    logic               stream_end = 1'b0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [31:0]        record_offset;
    logic [1:0]         status;
    logic               final_res;

    keyed_record_extractor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .stream_end   (stream_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .value        (value),
        .record_offset(record_offset),
        .status       (status),
        .final_res    (final_res)
    );

    // shadow parser state
    logic [127:0] key_bytes   = '0;
    logic [4:0]   field_cnt   = '0;
    logic [127:0] win_bytes   = '0;
    int           win_fill    = 0;
    logic [31:0]  seen_cnt    = '0;
    phase_t       rec_phase   = PH_SEARCH;
    logic [4:0]   field_idx   = '0;
    logic [1:0]   byte_pos    = '0;
    logic [31:0]  accum       = '0;
    logic [15:0]  text_left   = '0;
    logic [31:0]  match_off   = '0;

    in_word_t stream_q[$];
    res_t     parsed_q[$];
    in_word_t next_word;
    res_t     want;

    bit in_taken   = 1'b0;
    bit calm       = 1'b0;
    bit held       = 1'b0;
    int send_gap   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int cycles     = 0;
    int fails      = 0;
    int words_in   = 0;
    int words_made = 0;
    int streams    = 0;
    int results    = 0;
    int n_fields   = 0;
    int n_lengths  = 0;
    int n_text     = 0;
    int n_missing  = 0;
    int n_cut      = 0;

    function automatic logic [4:0] fields_due();
        return (field_cnt > DEF_MAX_FIELDS) ? 5'(DEF_MAX_FIELDS) : field_cnt;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic e);
        res_t        r;
        bit          emit;
        logic [31:0] pos;
        r.kind   = KIND_STATUS;
        r.value  = '0;
        r.offset = match_off;
        r.status = ST_OK;
        r.fin    = 1'b0;
        emit     = 1'b0;
        case (rec_phase)
            PH_SEARCH:
            begin
                pos       = seen_cnt;
                win_bytes = {win_bytes[119:0], b};
                if (win_fill < 16)
                    win_fill++;
                seen_cnt = seen_cnt + 32'd1;
                if (win_fill >= DEF_KEY_BYTES && win_bytes == key_bytes)
                begin
                    match_off = pos - 32'(DEF_KEY_BYTES - 1);
                    r.offset  = match_off;
                    emit      = 1'b1;
                    field_idx = '0;
                    byte_pos  = '0;
                    accum     = '0;
                    rec_phase = (fields_due() != 0) ? PH_FIELDS : PH_LENGTH;
                    if (e)
                    begin
                        r.status = ST_TRUNC_LEN;
                        r.fin    = 1'b1;
                    end
                end
                else if (e)
                begin
                    emit     = 1'b1;
                    r.offset = '0;
                    r.status = ST_NOT_FOUND;
                    r.fin    = 1'b1;
                end
            end
            PH_FIELDS:
            begin
                accum = {accum[23:0], b};
                if (byte_pos == 2'd3)
                begin
                    emit      = 1'b1;
                    r.kind    = KIND_INT;
                    r.value   = accum;
                    field_idx = field_idx + 5'd1;
                    byte_pos  = '0;
                    accum     = '0;
                    if (field_idx >= fields_due())
                        rec_phase = PH_LENGTH;
                end
                else
                    byte_pos = byte_pos + 2'd1;
                if (e)
                begin
                    emit     = 1'b1;
                    r.status = ST_TRUNC_LEN;
                    r.fin    = 1'b1;
                end
            end
            PH_LENGTH:
            begin
                accum = {16'h0, accum[7:0], b};
                if (byte_pos != 0)
                begin
                    emit      = 1'b1;
                    r.kind    = KIND_LENGTH;
                    r.value   = accum;
                    text_left = accum[15:0];
                    byte_pos  = '0;
                    accum     = '0;
                    if (text_left == 0)
                    begin
                        rec_phase = PH_DONE;
                        r.fin     = 1'b1;
                    end
                    else
                    begin
                        rec_phase = PH_TEXT;
                        if (e)
                        begin
                            r.status = ST_TRUNC_TEXT;
                            r.fin    = 1'b1;
                        end
                    end
                end
                else
                begin
                    byte_pos = 2'd1;
                    if (e)
                    begin
                        emit     = 1'b1;
                        r.status = ST_TRUNC_LEN;
                        r.fin    = 1'b1;
                    end
                end
            end
            PH_TEXT:
            begin
                emit      = 1'b1;
                r.kind    = KIND_TEXT;
                r.value   = {24'h0, b};
                text_left = text_left - 16'd1;
                if (text_left == 0)
                begin
                    rec_phase = PH_DONE;
                    r.fin     = 1'b1;
                end
                else if (e)
                begin
                    r.status = ST_TRUNC_TEXT;
                    r.fin    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (e)
        begin
            win_bytes = '0;
            win_fill  = 0;
            seen_cnt  = '0;
            rec_phase = PH_SEARCH;
            field_idx = '0;
            byte_pos  = '0;
            accum     = '0;
            text_left = '0;
            match_off = '0;
        end
        if (emit)
            parsed_q.push_back(r);
    endfunction

    // cut: 0 keeps the whole stream, -1 picks a random cut, else a byte count capped at the stream length.
    // close: mark the last byte as stream end.
    task automatic push_stream(input int pre, input bit keyed, input int nfields,
                               input logic [15:0] len, input int ntext, input int tail,
                               input int cut, input bit close);
        logic [7:0]  bq[$];
        logic [31:0] fv;
        in_word_t    w;
        int          n;
        repeat (pre) bq.push_back(8'($urandom));
        if (keyed)
            for (int i = 0; i < 16; i++)
                bq.push_back(key_bytes[127 - 8 * i -: 8]);
        repeat (nfields)
        begin
            case ($urandom_range(0, 7))
                0: fv = 32'h0000_0000;
                1: fv = 32'h7FFF_FFFF;
                2: fv = 32'h8000_0000;
                3: fv = 32'hFFFF_FFFF;
                default: fv = $urandom;
            endcase
            for (int i = 3; i >= 0; i--)
                bq.push_back(fv[8 * i +: 8]);
        end
        bq.push_back(len[15:8]);
        bq.push_back(len[7:0]);
        repeat (ntext) bq.push_back(8'($urandom));
        repeat (tail) bq.push_back(8'($urandom));
        n = bq.size();
        if (cut < 0)
            n = $urandom_range(1, bq.size());
        else if (cut > 0 && cut < n)
            n = cut;
        for (int i = 0; i < n; i++)
        begin
            w.b = bq[i];
            w.e = close && (i == n - 1);
            stream_q.push_back(w);
        end
        words_made += n;
        if (close)
            streams++;
    endtask

    task automatic random_stream();
        int          r;
        int          pre;
        int          ntext;
        int          tail;
        logic [15:0] len;
        r   = $urandom_range(0, 9);
        pre = $urandom_range(0, 8);
        if (r == 0)
            push_stream($urandom_range(1, 40), 1'b0, 0, 16'($urandom), 0, 0, 0, 1'b1);
        else
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                len   = 16'($urandom);
                ntext = $urandom_range(0, 6);
                tail  = 0;
            end
            else
            begin
                len   = 16'($urandom_range(0, 12));
                ntext = int'(len);
                tail  = $urandom_range(0, 3);
            end
            push_stream(pre, 1'b1, int'(fields_due()), len, ntext, tail,
                        (r <= 2) ? -1 : 0, 1'b1);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            CFG_KEY_UPPER:   key_bytes[127:64] = d;
            CFG_KEY_LOWER:   key_bytes[63:0]   = d;
            CFG_FIELD_COUNT: field_cnt         = d[4:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] cnt);
        write_reg(CFG_KEY_UPPER, hi);
        write_reg(CFG_KEY_LOWER, lo);
        write_reg(CFG_FIELD_COUNT, {59'h0, cnt});
    endtask

    task automatic wait_idle();
        while (stream_q.size() != 0 || in_valid || parsed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     parsed_q.size());
            $display("keyed_record_extractor verification failed");
            $finish;
        end
    end

    // input side: acceptance and shadow parse
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            parse_byte(data_byte, stream_end);
            words_in++;
            in_taken = 1'b1;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (in_taken || !in_valid)
        begin
            in_taken = 1'b0;
            if (send_gap == 0 && !calm && $urandom_range(0, 9) == 0)
                send_gap = $urandom_range(1, 16);
            if (send_gap > 0 || stream_q.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_word = stream_q.pop_front();
                in_valid   <= 1'b1;
                data_byte  <= next_word.b;
                stream_end <= next_word.e;
            end
        end
    end

    // receiver stall, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (!held && words_in >= 350)
        begin
            held      = 1'b1;
            hold_left = 120;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (parsed_q.size() == 0)
            begin
                $error("result with nothing pending: kind %0d value %0d status %0d",
                       kind, value, status);
                fails++;
            end
            else
            begin
                want = parsed_q.pop_front();
                results++;
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    fails++;
                end
                if (value !== want.value)
                begin
                    $error("value: expected %0d, got %0d", $signed(want.value), value);
                    fails++;
                end
                if (record_offset !== want.offset)
                begin
                    $error("record_offset: expected %0d, got %0d", want.offset, record_offset);
                    fails++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fails++;
                end
                if (final_res !== want.fin)
                begin
                    $error("final_res: expected %0d, got %0d", want.fin, final_res);
                    fails++;
                end
                case (want.kind)
                    KIND_INT:    n_fields++;
                    KIND_LENGTH: n_lengths++;
                    KIND_TEXT:   n_text++;
                    default:
                    begin
                    end
                endcase
                if (want.status == ST_NOT_FOUND)
                    n_missing++;
                else if (want.status != ST_OK)
                    n_cut++;
            end
        end
    end

    initial
    begin
        logic [63:0] hi;
        logic [63:0] lo;
        int          target;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
        set_config(hi, lo, 5'd2);
        push_stream(0, 1'b0, 0, 16'hA5FF, 0, 0, 1, 1'b1);          // one-byte stream
        push_stream(3, 1'b1, 2, 16'h0, 0, 0, 3 + 16, 1'b1);         // match on last byte
        push_stream(1, 1'b1, 2, 16'h0, 0, 2, 0, 1'b1);              // empty text, junk after
        push_stream(0, 1'b1, 2, 16'h0, 0, 0, 16 + 5, 1'b1);         // end inside a field
        push_stream(0, 1'b1, 2, 16'h0, 0, 0, 16 + 8, 1'b1);         // end on a field
        push_stream(0, 1'b1, 2, 16'h0, 0, 0, 16 + 9, 1'b1);         // end inside the length
        push_stream(0, 1'b1, 2, 16'hFFFF, 1, 0, 0, 1'b1);           // text cut short
        push_stream(0, 1'b1, 2, 16'h8000, 0, 0, 0, 1'b1);           // end on the length
        push_stream(0, 1'b1, 2, 16'd3, 3, 0, 0, 1'b1);              // end on last text byte
        wait_idle();

        set_config('1, '1, 5'd0);
        push_stream(2, 1'b1, 0, 16'd1, 1, 1, 0, 1'b1);
        wait_idle();
        set_config('0, '0, 5'd20);                                    // count saturates
        push_stream(4, 1'b1, 16, 16'd2, 2, 0, 0, 1'b1);
        wait_idle();

        // shrink the field count in the middle of a record
        write_reg(CFG_FIELD_COUNT, 64'd3);
        push_stream(2, 1'b1, 1, 16'h0, 0, 0, 2 + 16 + 4 + 2, 1'b0);
        wait_idle();
        write_reg(CFG_FIELD_COUNT, 64'd1);
        push_stream(2, 1'b0, 0, 16'd2, 2, 1, 0, 1'b1);
        wait_idle();

        for (int p = 0; p < 5; p++)
        begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            case (p)
                0: set_config(hi, lo, 5'd16);
                1: set_config(hi, lo, 5'd0);
                2: set_config(hi, lo, 5'd1);
                default: set_config(hi, lo, 5'($urandom_range(0, 16)));
            endcase
            calm   = (p == 4);
            target = words_made + PHASE_WORDS;
            while (words_made < target)
                random_stream();
            wait_idle();
        end

        $display("Ran %0d streams, %0d bytes in, %0d results checked.", streams, words_in,
                 results);
        $display("Results: %0d fields, %0d lengths, %0d text bytes, %0d no-key, %0d cut short.",
                 n_fields, n_lengths, n_text, n_missing, n_cut);
        if (fails == 0)
            $display("keyed_record_extractor verification clean");
        else
            $display("keyed_record_extractor verification failed");
        $finish;
    end
endmodule
